[src/ipdr_pkg.sv]
// shared types, constants and helpers for the ir pulse-distance receiver
`timescale 1ns / 1ps

package ipdr_pkg;

  // field widths fixed by the channel definitions
  localparam int REQ_W  = 2;
  localparam int TICK_W = 8;
  localparam int IDX_W  = 4;
  localparam int LEN_W  = 4;
  localparam int BYTE_W = 8;
  localparam int BCNT_W = 3;

  // default frame buffer depth in bytes
  localparam int FRAME_BYTES_DEF = 10;

  // length of the boot keyword
  localparam int BOOT_LEN = 4;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_EDGE    = 2'd0,
    REQ_TIMEOUT = 2'd1,
    REQ_READ    = 2'd2,
    REQ_RELEASE = 2'd3
  } req_t;

  // one result item
  typedef struct packed {
    logic              frame_ready;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] read_data;
    logic              boot_request;
    logic              receiving;
  } res_t;

  // expected keyword character at a byte position
  function automatic logic [BYTE_W-1:0] boot_char(input logic [1:0] pos);
    logic [BYTE_W-1:0] c;
    case (pos)
      2'd0:    c = 8'h42;  // 'B'
      2'd1:    c = 8'h4F;  // 'O'
      2'd2:    c = 8'h4F;  // 'O'
      default: c = 8'h54;  // 'T'
    endcase
    return c;
  endfunction

endpackage

[src/ipdr_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps

interface ipdr_req_if;
  logic                        valid;
  logic                        ready;
  logic [ipdr_pkg::REQ_W-1:0]  req_type;
  logic                        edge_falling;
  logic [ipdr_pkg::TICK_W-1:0] elapsed_ticks;
  logic [ipdr_pkg::IDX_W-1:0]  read_index;

  modport source (output valid, req_type, edge_falling, elapsed_ticks, read_index,
                  input ready);
  modport sink (input valid, req_type, edge_falling, elapsed_ticks, read_index,
                output ready);
endinterface

interface ipdr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        frame_ready;
  logic [ipdr_pkg::LEN_W-1:0]  frame_length;
  logic [ipdr_pkg::BYTE_W-1:0] read_data;
  logic                        boot_request;
  logic                        receiving;

  modport source (output valid, frame_ready, frame_length, read_data, boot_request,
                  receiving, input ready);
  modport sink (input valid, frame_ready, frame_length, read_data, boot_request,
                receiving, output ready);
endinterface

[src/ir_pulse_distance_receiver_top.sv]
// top level of the ir pulse-distance receiver
//
//   channel  dir  handshake    payload
//   req      in   valid/ready  req_type, edge_falling, elapsed_ticks, read_index
//   rsp      out  valid/ready  frame_ready, frame_length, read_data,
//                              boot_request, receiving
//
// one request per cycle while the output is not stalled; each request gives exactly one response
// from request transfer to response valid a result passes the result stage
// (state update plus frame buffer read), then the output register
// a two-entry output buffer keeps requests flowing during a stall while its spill entry is free
// rst is synchronous; the frame buffer is not cleared and needs no sweep
`timescale 1ns / 1ps

module ir_pulse_distance_receiver_top #(
  parameter int FRAME_BYTES = ipdr_pkg::FRAME_BYTES_DEF
) (
  input logic        clk,
  input logic        rst,
  ipdr_req_if.sink   req,
  ipdr_rsp_if.source rsp
);

  logic           res_valid;
  logic           res_ready;
  ipdr_pkg::res_t res;

  // decoder, state and frame buffer
  ipdr_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // output buffering
  ipdr_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (res_valid),
    .push_data  (res),
    .push_ready (res_ready),
    .rsp        (rsp)
  );

endmodule

[src/ipdr_ram.sv]
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module ipdr_ram #(
  parameter int WIDTH = ipdr_pkg::BYTE_W,
  parameter int DEPTH = ipdr_pkg::FRAME_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/ipdr_core.sv]
// receiver state, edge decoding, frame buffer and result stage
`timescale 1ns / 1ps

module ipdr_core #(
  parameter int FRAME_BYTES = ipdr_pkg::FRAME_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  ipdr_req_if.sink        req,
  output logic            res_valid,
  output ipdr_pkg::res_t  res,
  input  logic            res_ready
);

  localparam int POS_W = $clog2(FRAME_BYTES + 1);
  localparam int AW    = $clog2(FRAME_BYTES);
  localparam int CMP_W = (POS_W > ipdr_pkg::IDX_W) ? POS_W : ipdr_pkg::IDX_W;
  localparam int RD_W  = (AW > ipdr_pkg::IDX_W) ? AW : ipdr_pkg::IDX_W;

  // receiver state
  logic [ipdr_pkg::TICK_W-1:0] sync_len, sync_len_next;
  logic [ipdr_pkg::BYTE_W-1:0] part, part_next;
  logic [ipdr_pkg::BCNT_W-1:0] bcnt, bcnt_next;
  logic [POS_W-1:0]            wpos, wpos_next;
  logic [POS_W-1:0]            rlen, rlen_next;
  logic                        active, active_next;
  logic                        boot_match, boot_match_next;

  // result stage
  logic                        a_valid;
  logic                        a_frame_ready;
  logic [ipdr_pkg::LEN_W-1:0]  a_frame_length;
  logic                        a_boot;
  logic                        a_receiving;
  logic                        a_rd_hit;

  logic                        take;
  logic                        boot;
  logic                        is_long;
  logic [ipdr_pkg::TICK_W:0]   twice;
  logic [ipdr_pkg::BYTE_W-1:0] shifted;
  logic                        ram_we;
  logic [ipdr_pkg::BYTE_W-1:0] ram_q;
  logic [RD_W-1:0]             idx_ext;
  logic [CMP_W-1:0]            len_ext;
  logic                        rd_hit;

  // handshake: the result stage empties or moves on
  assign req.ready = !a_valid || res_ready;
  assign take      = req.valid && req.ready;

  assign twice   = {sync_len, 1'b0};
  assign is_long = {1'b0, req.elapsed_ticks} > twice;
  assign shifted = {is_long, part[ipdr_pkg::BYTE_W-1:1]};

  // next-state decode for one request
  always_comb begin
    sync_len_next   = sync_len;
    part_next       = part;
    bcnt_next       = bcnt;
    wpos_next       = wpos;
    rlen_next       = rlen;
    active_next     = active;
    boot_match_next = boot_match;
    ram_we          = 1'b0;
    boot            = 1'b0;
    unique case (ipdr_pkg::req_t'(req.req_type))
      ipdr_pkg::REQ_EDGE: begin
        if (rlen == '0) begin
          if (req.edge_falling) begin
            active_next = 1'b1;
            if (sync_len != '0) begin
              if (bcnt == {ipdr_pkg::BCNT_W{1'b1}}) begin
                // byte complete
                part_next = '0;
                bcnt_next = '0;
                if (wpos < POS_W'(FRAME_BYTES)) begin
                  ram_we    = 1'b1;
                  wpos_next = wpos + POS_W'(1);
                  if (wpos < POS_W'(ipdr_pkg::BOOT_LEN)) begin
                    boot_match_next = boot_match &&
                                      (shifted == ipdr_pkg::boot_char(wpos[1:0]));
                  end
                end
                if (wpos_next >= POS_W'(FRAME_BYTES)) begin
                  rlen_next = wpos_next;
                end
              end else begin
                part_next = shifted;
                bcnt_next = bcnt + ipdr_pkg::BCNT_W'(1);
              end
            end
          end else if (sync_len != '0 && is_long) begin
            // end pulse closes the frame
            rlen_next       = wpos;
            boot            = (wpos == POS_W'(ipdr_pkg::BOOT_LEN)) && boot_match;
            wpos_next       = '0;
            part_next       = '0;
            bcnt_next       = '0;
            sync_len_next   = '0;
            boot_match_next = 1'b1;
          end else begin
            sync_len_next = req.elapsed_ticks;
          end
        end
      end
      ipdr_pkg::REQ_TIMEOUT: begin
        wpos_next       = '0;
        part_next       = '0;
        bcnt_next       = '0;
        sync_len_next   = '0;
        boot_match_next = 1'b1;
        active_next     = 1'b0;
      end
      ipdr_pkg::REQ_READ: begin
      end
      ipdr_pkg::REQ_RELEASE: begin
        wpos_next       = '0;
        part_next       = '0;
        bcnt_next       = '0;
        sync_len_next   = '0;
        boot_match_next = 1'b1;
        active_next     = 1'b0;
        rlen_next       = '0;
      end
      default: begin
      end
    endcase
  end

  // read hit check against the ready length
  assign idx_ext = RD_W'(req.read_index);
  assign len_ext = CMP_W'(rlen_next);
  assign rd_hit  = (ipdr_pkg::req_t'(req.req_type) == ipdr_pkg::REQ_READ) &&
                   (CMP_W'(req.read_index) < len_ext);

  // frame buffer
  ipdr_ram #(
    .WIDTH (ipdr_pkg::BYTE_W),
    .DEPTH (FRAME_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (take && ram_we),
    .waddr (wpos[AW-1:0]),
    .wdata (shifted),
    .re    (take),
    .raddr (idx_ext[AW-1:0]),
    .rdata (ram_q)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_len   <= '0;
      part       <= '0;
      bcnt       <= '0;
      wpos       <= '0;
      rlen       <= '0;
      active     <= 1'b0;
      boot_match <= 1'b1;
    end else if (take) begin
      sync_len   <= sync_len_next;
      part       <= part_next;
      bcnt       <= bcnt_next;
      wpos       <= wpos_next;
      rlen       <= rlen_next;
      active     <= active_next;
      boot_match <= boot_match_next;
    end
  end

  // result stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req.ready) begin
      a_valid <= req.valid;
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      a_frame_ready  <= (rlen_next != '0);
      a_frame_length <= len_ext[ipdr_pkg::LEN_W-1:0];
      a_boot         <= boot;
      a_receiving    <= active_next;
      a_rd_hit       <= rd_hit;
    end
  end

  // read data comes straight from the ram output register on a read hit, else zero
  assign res_valid        = a_valid;
  assign res.frame_ready  = a_frame_ready;
  assign res.frame_length = a_frame_length;
  assign res.read_data    = a_rd_hit ? ram_q : '0;
  assign res.boot_request = a_boot;
  assign res.receiving    = a_receiving;

endmodule

[src/ipdr_skid.sv]
// two-entry output buffer so the core keeps accepting during a stall while the spill entry is free
`timescale 1ns / 1ps

module ipdr_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  ipdr_pkg::res_t push_data,
  output logic           push_ready,
  ipdr_rsp_if.source     rsp
);

  logic           out_valid;
  ipdr_pkg::res_t out_data;
  logic           skid_valid;
  ipdr_pkg::res_t skid_data;

  assign push_ready = !skid_valid;

  // output and spill registers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push_valid;
      end
    end else if (push_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || rsp.ready) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push_valid) begin
        out_data <= push_data;
      end
    end else if (push_valid && !skid_valid) begin
      skid_data <= push_data;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.frame_ready  = out_data.frame_ready;
  assign rsp.frame_length = out_data.frame_length;
  assign rsp.read_data    = out_data.read_data;
  assign rsp.boot_request = out_data.boot_request;
  assign rsp.receiving    = out_data.receiving;

endmodule

[src/ipdr_checker.sv]
// port-level checks for the ir pulse-distance receiver, bound to the top level
`timescale 1ns / 1ps

module ipdr_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_frame_ready,
  input logic [ipdr_pkg::LEN_W-1:0]  rsp_frame_length,
  input logic [ipdr_pkg::BYTE_W-1:0] rsp_read_data,
  input logic                        rsp_boot_request,
  input logic                        rsp_receiving
);

  logic [2:0] in_flight;

  // requests taken minus responses delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 3'(req_valid && req_ready) - 3'(rsp_valid && rsp_ready);
    end
  end

  // at most three items held inside
  a_depth: assert property (@(posedge clk) disable iff (rst) in_flight <= 3'd3)
    else $error("more items in flight than the pipeline holds");

  // no response without a pending request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> in_flight != 3'd0)
    else $error("response without an outstanding request");

  // boot request only with a ready four-byte frame
  a_boot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_boot_request |-> rsp_frame_ready && rsp_frame_length == 4'd4)
    else $error("boot request without a four-byte frame");

  // stalled response keeps valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // stalled response keeps payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_frame_ready) && $stable(rsp_frame_length) &&
      $stable(rsp_read_data) && $stable(rsp_boot_request) && $stable(rsp_receiving))
    else $error("response payload changed while stalled");

endmodule

bind ir_pulse_distance_receiver_top ipdr_checker u_ipdr_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_frame_ready  (rsp.frame_ready),
  .rsp_frame_length (rsp.frame_length),
  .rsp_read_data    (rsp.read_data),
  .rsp_boot_request (rsp.boot_request),
  .rsp_receiving    (rsp.receiving)
);
